[rtl/lpbr_pkg.sv]
`default_nettype none

package lpbr_pkg;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_STATUS = 2'd1,
		REQ_WRITE  = 2'd2,
		REQ_BYTE   = 2'd3
	} req_t;

	localparam logic [1:0] LINES_ALL   = 2'b11;
	localparam logic [1:0] LINE_TIP    = 2'b01;
	localparam logic [1:0] LINE_RING   = 2'b10;
	localparam logic [3:0] BITS_BYTE   = 4'd8;
	localparam int         CTRL_ENABLE = 2;

	// Architectural state of the port and its byte-receive assist.
	typedef struct packed {
		logic [1:0] host_drive;
		logic       assist_enable;
		logic       receiving;
		logic       done;
		logic       ready;
		logic [3:0] bit_count;
		logic [7:0] shift_byte;
		logic [7:0] latched_byte;
	} state_t;

	typedef struct packed {
		logic       byte_waiting;
		logic       assist_ready;
		logic [1:0] host_lines;
		logic [7:0] read_data;
	} result_t;

endpackage

`default_nettype wire

[rtl/lpbr_step.sv]
`default_nettype none

module lpbr_step (
	input  var lpbr_pkg::req_t    req,
	input  var logic [7:0]        write_data,
	input  var logic [1:0]        client_lines,
	input  var lpbr_pkg::state_t  cur,
	output var lpbr_pkg::state_t  nxt,
	output var lpbr_pkg::result_t res
);
	import lpbr_pkg::*;

	logic [1:0] low;
	logic [3:0] count_base;
	logic       latch;

	// A set bit in low means neither side is pulling that line low.
	assign low        = ~(cur.host_drive | client_lines);
	assign count_base = cur.receiving ? cur.bit_count : 4'd0;

	always_comb begin
		nxt   = cur;
		latch = 1'b0;
		res.read_data = 8'd0;
		case (req)
			REQ_TICK: begin
				if (cur.assist_enable) begin
					if (low != LINES_ALL) begin
						nxt.ready = 1'b0;
					end
					if (low == LINE_TIP || low == LINE_RING) begin
						if (cur.bit_count < BITS_BYTE) begin
							nxt.receiving = 1'b1;
							nxt.bit_count = count_base;
							if (cur.host_drive == 2'd0) begin
								// Ring pulled low carries a one; bits arrive LSB first.
								nxt.shift_byte = {low == LINE_TIP, cur.shift_byte[7:1]};
								nxt.bit_count  = count_base + 4'd1;
								nxt.host_drive = low;
							end else begin
								nxt.host_drive = 2'd0;
							end
						end else if (cur.bit_count == BITS_BYTE) begin
							nxt.host_drive = 2'd0;
							latch = !cur.done;
						end
					end else if (low == LINES_ALL) begin
						if (cur.bit_count >= BITS_BYTE && !cur.done) begin
							latch = 1'b1;
						end else if (cur.bit_count == 4'd0) begin
							nxt.ready = 1'b1;
						end
					end
				end
			end
			REQ_STATUS: begin
				res.read_data = {1'b0, cur.receiving, 2'b00, cur.done,
					cur.assist_enable, low};
			end
			REQ_WRITE: begin
				nxt.assist_enable = write_data[CTRL_ENABLE];
				nxt.host_drive    = write_data[1:0];
			end
			REQ_BYTE: begin
				nxt.done      = 1'b0;
				res.read_data = cur.latched_byte;
			end
			default: begin
				nxt = cur;
			end
		endcase
		if (latch) begin
			nxt.latched_byte = cur.shift_byte;
			nxt.done         = 1'b1;
			nxt.receiving    = 1'b0;
			nxt.bit_count    = 4'd0;
		end
		res.host_lines   = nxt.host_drive;
		res.assist_ready = nxt.ready;
		res.byte_waiting = nxt.done;
	end

endmodule

`default_nettype wire

[rtl/link_port_byte_receiver_core.sv]
// Channel | Direction | tdata (LSB up)                                   | tuser
// s_*     | in        | write_data[7:0], client_lines[9:8], zero [15:10]  | req_type[1:0]
// m_*     | out       | read_data[7:0], host_lines[9:8], assist_ready[10],|
//         |           | byte_waiting[11], zero [15:12]                    | -
//
// Every request yields exactly one result, registered in order through
// an input register, then the state update and result register.
// One item per clock is sustained while m_tready stays high.
// A low m_tready holds the result register and the input register; the
// input side stalls only when both are full.
// arst_n clears all port and assist state and both valid flags.
`default_nettype none

module link_port_byte_receiver_core (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        s_tvalid,
	output var logic        s_tready,
	input  var logic [15:0] s_tdata,   // write_data, client_lines
	input  var logic [1:0]  s_tuser,   // req_type
	output var logic        m_tvalid,
	input  var logic        m_tready,
	output var logic [15:0] m_tdata    // read_data, host_lines, assist_ready, byte_waiting
);
	import lpbr_pkg::*;

	logic       valid_s1;
	req_t       req_s1;
	logic [7:0] wdata_s1;
	logic [1:0] client_s1;
	logic       advance;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;
	result_t    res_q;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1    <= req_t'(s_tuser);
			wdata_s1  <= s_tdata[7:0];
			client_s1 <= s_tdata[9:8];
		end
	end

	lpbr_step u_step (
		.req          (req_s1),
		.write_data   (wdata_s1),
		.client_lines (client_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign m_tdata = {4'd0, res_q};

`ifndef NO_ASSERTIONS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_count <= BITS_BYTE)
		else $error("bit count beyond one byte");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ready |-> state_q.bit_count == 4'd0)
		else $error("assist ready with bits pending");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register item dropped during stall");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> m_tvalid)
		else $error("item lost between input and result registers");

	a_lines_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> m_tdata[9:8] == state_q.host_drive)
		else $error("reported host lines differ from the line drive");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lpbr_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_REQUESTS = 400;
	localparam logic [1:0] LINES_NONE = 2'b00;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	// Predicted port and assist state.
	logic [1:0] host_drv;
	logic       asst_en;
	logic       rx_flg;
	logic       done_flg;
	logic       rdy_flg;
	logic [3:0] bit_cnt;
	logic [7:0] shift_reg;
	logic [7:0] byte_latch;

	result_t pending_port_results[$];
	int      requests_sent;
	int      mismatch_count;
	int      burst_left;
	int      hold_request;
	int      hold_left;
	int      rx_mode;
	int      rx_window;
	int      pattern_count;
	int      idle_cycles;

	link_port_byte_receiver_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic void latch_received_byte();
		byte_latch = shift_reg;
		done_flg = 1'b1;
		rx_flg = 1'b0;
		bit_cnt = 4'd0;
	endfunction

	function automatic result_t predict_port_result(req_t req, logic [7:0] data,
			logic [1:0] client);
		result_t    r;
		logic [1:0] low;
		r = '0;
		// A set bit in low means neither side is holding that line low.
		low = ~(host_drv | client);
		case (req)
			REQ_TICK: if (asst_en) begin
				if (low != LINES_ALL)
					rdy_flg = 1'b0;
				if (low == LINE_TIP || low == LINE_RING) begin
					if (bit_cnt < BITS_BYTE) begin
						// A fresh reception always restarts the bit count.
						if (!rx_flg)
							bit_cnt = 4'd0;
						rx_flg = 1'b1;
						if (host_drv == LINES_NONE) begin
							shift_reg = {low == LINE_TIP, shift_reg[7:1]};
							bit_cnt = bit_cnt + 4'd1;
							host_drv = low;
						end else begin
							host_drv = LINES_NONE;
						end
					end else if (bit_cnt == BITS_BYTE) begin
						host_drv = LINES_NONE;
						if (!done_flg)
							latch_received_byte();
					end
				end else if (low == LINES_ALL) begin
					if (bit_cnt >= BITS_BYTE && !done_flg)
						latch_received_byte();
					else if (bit_cnt == 4'd0)
						rdy_flg = 1'b1;
				end
			end
			REQ_STATUS: r.read_data = {1'b0, rx_flg, 2'b00, done_flg, asst_en, low};
			REQ_WRITE: begin
				asst_en = data[CTRL_ENABLE];
				host_drv = data[1:0];
			end
			REQ_BYTE: begin
				done_flg = 1'b0;
				r.read_data = byte_latch;
			end
			default: begin
				r.read_data = 8'h00;
			end
		endcase
		r.host_lines = host_drv;
		r.assist_ready = rdy_flg;
		r.byte_waiting = done_flg;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] wanted);
		$display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, wanted);
		mismatch_count++;
	endtask

	// Offers one item, with bursts and random gaps, and predicts it once accepted.
	task automatic send_request(req_t req, logic [7:0] data, logic [1:0] client);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {6'b000000, client, data};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_port_results.push_back(predict_port_result(req, data, client));
		requests_sent++;
	endtask

	task automatic send_noise();
		send_request(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			2'($urandom_range(0, 3)));
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_port_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_status_and_control();
		send_request(REQ_STATUS, 8'h00, LINES_NONE);
		send_request(REQ_STATUS, 8'hFF, LINE_TIP);
		send_request(REQ_STATUS, 8'h00, LINE_RING);
		send_request(REQ_STATUS, 8'hFF, LINES_ALL);
		send_request(REQ_BYTE, 8'h00, LINES_NONE);
		// The assist ignores ticks while disabled.
		send_request(REQ_TICK, 8'h00, LINE_TIP);
		send_request(REQ_WRITE, 8'hFF, LINES_NONE);
		send_request(REQ_STATUS, 8'h00, LINES_NONE);
		send_request(REQ_TICK, 8'h00, LINES_NONE);
		send_request(REQ_WRITE, 8'hFB, LINES_ALL);
		send_request(REQ_STATUS, 8'h00, LINES_NONE);
		wait_for_results();
	endtask

	task automatic test_bit_handshake();
		send_request(REQ_WRITE, 8'h04, LINES_NONE);
		send_request(REQ_TICK, 8'h00, LINES_NONE);
		send_request(REQ_STATUS, 8'h00, LINES_NONE);
		send_request(REQ_TICK, 8'h00, LINE_RING);
		send_request(REQ_TICK, 8'h00, LINES_ALL);
		send_request(REQ_TICK, 8'h00, LINES_NONE);
		send_request(REQ_TICK, 8'h00, LINE_TIP);
		send_request(REQ_TICK, 8'h00, LINES_NONE);
		// Host drive is overwritten in the middle of a reception.
		send_request(REQ_WRITE, 8'h06, LINES_NONE);
		send_request(REQ_STATUS, 8'h00, LINES_NONE);
		send_request(REQ_WRITE, 8'h00, LINES_NONE);
		send_request(REQ_BYTE, 8'h00, LINES_NONE);
		wait_for_results();
	endtask

	task automatic test_output_stall();
		int k;
		hold_request = 60;
		for (k = 0; k < 16; k++)
			send_request($urandom_range(0, 1) ? REQ_STATUS : REQ_TICK,
				8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
		wait_for_results();
	endtask

	// One byte from the partner: it pulls ring for a one and tip for a zero,
	// then releases once the host has acknowledged on the other line.
	task automatic send_byte_frame();
		logic [7:0] value;
		logic [7:0] ctrl;
		int         k;
		value = 8'($urandom_range(0, 255));
		ctrl = 8'($urandom_range(0, 255));
		ctrl[CTRL_ENABLE] = 1'b1;
		ctrl[1:0] = LINES_NONE;
		if ($urandom_range(0, 3) != 0)
			send_request(REQ_WRITE, ctrl, 2'($urandom_range(0, 3)));
		repeat ($urandom_range(1, 2))
			send_request(REQ_TICK, 8'($urandom_range(0, 255)), LINES_NONE);
		for (k = 0; k < 8; k++) begin
			repeat ($urandom_range(1, 3))
				send_request(REQ_TICK, 8'($urandom_range(0, 255)),
					value[k] ? LINE_RING : LINE_TIP);
			if ($urandom_range(0, 7) == 0)
				send_request(REQ_STATUS, 8'($urandom_range(0, 255)),
					2'($urandom_range(0, 3)));
			repeat ($urandom_range(1, 2))
				send_request(REQ_TICK, 8'($urandom_range(0, 255)), LINES_NONE);
			if ($urandom_range(0, 24) == 0)
				send_noise();
		end
		send_request(REQ_TICK, 8'($urandom_range(0, 255)), LINES_NONE);
		send_request(REQ_STATUS, 8'($urandom_range(0, 255)), LINES_NONE);
		// Leaving the byte unread now and then makes the next frame hold.
		if ($urandom_range(0, 4) != 0)
			send_request(REQ_BYTE, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
	endtask

	task automatic test_random_traffic();
		int start;
		start = requests_sent;
		while (requests_sent - start < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 9) < 7)
				send_byte_frame();
			else
				repeat ($urandom_range(1, 4)) send_noise();
		end
		wait_for_results();
	endtask

	// Receiver: windows of steady readiness, random or patterned stalls, plus a requested hold-off.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		pattern_count++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_window == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_window = $urandom_range(8, 64);
			end else begin
				rx_window--;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 99) >= 35);
				default: m_tready <= ((pattern_count % 7) < 4);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_port_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 16'h0000);
			end else begin
				want = pending_port_results.pop_front();
				if (m_tdata[7:0] !== want.read_data)
					report_mismatch("read_data", 16'(m_tdata[7:0]), 16'(want.read_data));
				if (m_tdata[9:8] !== want.host_lines)
					report_mismatch("host_lines", 16'(m_tdata[9:8]), 16'(want.host_lines));
				if (m_tdata[10] !== want.assist_ready)
					report_mismatch("assist_ready", 16'(m_tdata[10]),
						16'(want.assist_ready));
				if (m_tdata[11] !== want.byte_waiting)
					report_mismatch("byte_waiting", 16'(m_tdata[11]),
						16'(want.byte_waiting));
				if (m_tdata[15:12] !== 4'h0)
					report_mismatch("tdata padding", 16'(m_tdata[15:12]), 16'h0000);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		host_drv = LINES_NONE;
		asst_en = 1'b0;
		rx_flg = 1'b0;
		done_flg = 1'b0;
		rdy_flg = 1'b0;
		bit_cnt = 4'd0;
		shift_reg = 8'h00;
		byte_latch = 8'h00;
		requests_sent = 0;
		mismatch_count = 0;
		burst_left = 0;
		hold_request = 0;
		hold_left = 0;
		rx_mode = 0;
		rx_window = 0;
		pattern_count = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_status_and_control();
		test_bit_handshake();
		test_output_stall();
		test_random_traffic();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
